[sv/hpdc_pkg.sv]
`timescale 1ns / 1ps

package hpdc_pkg;

  // Timer ticks per microsecond of dead time
  localparam int TICKS_PER_US = 80;

  // Speed command full scale, hundredths of a percent
  localparam int FULL_SCALE = 10000;

  localparam int PERIOD_W = 16;
  localparam int DEAD_W   = 16;
  localparam int SPEED_W  = 16;
  localparam int MAG_W    = $clog2(FULL_SCALE + 1);
  localparam int PROD_W   = MAG_W + PERIOD_W;
  localparam int CNT_W    = DEAD_W + $clog2(TICKS_PER_US + 1);

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd4000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd2;

  // floor(x / FULL_SCALE) == (x * RECIP) >> RECIP_SHIFT, exact for x < 2**30
  localparam int                RECIP_SHIFT = 44;
  localparam int                RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP      = 31'd1759218605;
  localparam int                QPROD_W     = PROD_W + RECIP_W;

  // Register index, taken from paddr[2]
  localparam logic REG_PERIOD = 1'b0;
  localparam logic REG_DEAD   = 1'b1;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_SPEED = 2'd1,
    KIND_BRAKE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    MODE_COAST = 2'd0,
    MODE_BRAKE = 2'd1,
    MODE_DRIVE = 2'd2
  } mode_t;

  // Direction, two bit signed
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_FWD  = 2'b01;
  localparam logic [1:0] DIR_REV  = 2'b11;

  // Result beat, fwd_drive in bit 0
  typedef struct packed {
    logic       busy_reject;
    logic [1:0] direction_now;
    mode_t      mode_now;
    logic       bridge_enable;
    logic       rev_drive;
    logic       fwd_drive;
  } out_beat_t;

endpackage

[sv/hbridge_pwm_drive_controller.sv]
`timescale 1ns / 1ps

// H-bridge PWM drive controller.
// Input stream: in_tuser = kind (tick, speed command, brake), in_tdata = signed
// speed in hundredths of a percent. Every beat yields exactly one result beat
// on the output stream with the bridge levels, mode and direction after that
// beat, plus a reject flag for commands refused during reversal dead time.
// Config: APB-style port, reg 0 PWM period in ticks at 0x0, reg 1 dead_time_us at 0x4.
// Stages: the accept edge loads the input register; the magnitude*period multiply,
// the reciprocal multiply for /10000 and the state update into the output register
// follow in that order, each into its own register. Throughput: one beat per
// cycle while out_tready keeps the output moving; all control state is updated in
// the last stage only, so items chain back to back, stalled only by back-pressure.
// Each stage has its own valid, so input keeps being taken while an output beat
// waits, until the four stages are full; then in_tready drops.
// Reset (rst_n low, synchronous): pipeline empty, counter, compares and
// countdown zero, mode coast, period 4000, dead time 0.
// Dead time counts tick beats: dead_time_us * 80 ticks.
module hbridge_pwm_drive_controller (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] speed
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] fwd_drive [1] rev_drive [2] bridge_enable
                                  // [4:3] mode_now [6:5] direction_now [7] busy_reject
  // config
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PW = hpdc_pkg::PERIOD_W;
  localparam int CW = hpdc_pkg::CNT_W;

  // ---------------- configuration ----------------
  logic [PW-1:0]              period_r;
  logic [hpdc_pkg::DEAD_W-1:0] dead_us_r;
  logic [CW-1:0]              dead_ticks_r;   // dead_us_r * TICKS_PER_US
  logic                       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= hpdc_pkg::PERIOD_RESET;
      dead_us_r    <= '0;
      dead_ticks_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == hpdc_pkg::REG_PERIOD) begin
        period_r <= cfg_pwdata[PW-1:0];
      end else begin
        dead_us_r    <= cfg_pwdata[hpdc_pkg::DEAD_W-1:0];
        dead_ticks_r <= CW'(cfg_pwdata[hpdc_pkg::DEAD_W-1:0] * hpdc_pkg::TICKS_PER_US);
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == hpdc_pkg::REG_DEAD) begin
      cfg_prdata = {16'd0, dead_us_r};
    end else begin
      cfg_prdata = {16'd0, period_r};
    end
  end

  // period below 2 behaves as 2
  logic [PW-1:0] eff_period;
  assign eff_period = (period_r < hpdc_pkg::PERIOD_MIN) ? hpdc_pkg::PERIOD_MIN : period_r;

  // ---------------- pipeline handshake ----------------
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic step;   // stage 3 beat commits into state and output register

  assign rdy_o     = !vo_r || out_tready;
  assign rdy3      = !v3_r || rdy_o;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign step      = v3_r && rdy_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1)  v1_r <= in_tvalid;
      if (rdy2)  v2_r <= v1_r;
      if (rdy3)  v3_r <= v2_r;
      if (rdy_o) vo_r <= v3_r;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [1:0]                 s1_kind_r;
  logic signed [hpdc_pkg::SPEED_W-1:0] s1_speed_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_kind_r  <= in_tuser;
      s1_speed_r <= in_tdata;
    end
  end

  // saturate and take magnitude, then magnitude * period
  logic signed [hpdc_pkg::SPEED_W-1:0] sat;
  logic [hpdc_pkg::MAG_W-1:0]          mag;
  logic [hpdc_pkg::PROD_W-1:0]         prod;

  always_comb begin
    if (s1_speed_r > 16'sd10000) begin
      sat = 16'sd10000;
    end else if (s1_speed_r < -16'sd10000) begin
      sat = -16'sd10000;
    end else begin
      sat = s1_speed_r;
    end
    if (sat < 0) begin
      mag = hpdc_pkg::MAG_W'(-sat);
    end else begin
      mag = hpdc_pkg::MAG_W'(sat);
    end
    prod = hpdc_pkg::PROD_W'(mag) * hpdc_pkg::PROD_W'(eff_period);
  end

  // ---------------- stage 2: product ----------------
  logic [1:0]                  s2_kind_r;
  logic                        s2_neg_r;
  logic                        s2_zero_r;
  logic [hpdc_pkg::PROD_W-1:0] s2_prod_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_kind_r <= s1_kind_r;
      s2_neg_r  <= s1_speed_r[hpdc_pkg::SPEED_W-1];
      s2_zero_r <= (s1_speed_r == '0);
      s2_prod_r <= prod;
    end
  end

  // divide by full scale through the reciprocal
  logic [hpdc_pkg::QPROD_W-1:0] qprod;
  assign qprod = hpdc_pkg::QPROD_W'(s2_prod_r) * hpdc_pkg::QPROD_W'(hpdc_pkg::RECIP);

  // ---------------- stage 3: quotient ----------------
  logic [1:0]    s3_kind_r;
  logic          s3_neg_r;
  logic          s3_zero_r;
  logic [PW-1:0] s3_q_r;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_kind_r <= s2_kind_r;
      s3_neg_r  <= s2_neg_r;
      s3_zero_r <= s2_zero_r;
      s3_q_r    <= qprod[hpdc_pkg::RECIP_SHIFT +: PW];
    end
  end

  // ---------------- drive state ----------------
  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   fwd_live_r, fwd_live_nxt;
  logic [PW-1:0]   fwd_next_r, fwd_next_nxt;
  logic [PW-1:0]   rev_live_r, rev_live_nxt;
  logic [PW-1:0]   rev_next_r, rev_next_nxt;
  hpdc_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic [CW-1:0]   dead_cnt_r, dead_cnt_nxt;
  logic [PW-1:0]   pend_pulse_r, pend_pulse_nxt;
  logic            pend_rev_r, pend_rev_nxt;

  hpdc_pkg::out_beat_t out_r, out_nxt;

  logic [PW:0]   cnt_inc;
  logic [PW-1:0] pulse;
  logic [1:0]    cmd_dir;

  always_comb begin
    cnt_nxt        = cnt_r;
    fwd_live_nxt   = fwd_live_r;
    fwd_next_nxt   = fwd_next_r;
    rev_live_nxt   = rev_live_r;
    rev_next_nxt   = rev_next_r;
    mode_nxt       = mode_r;
    dir_nxt        = dir_r;
    dead_cnt_nxt   = dead_cnt_r;
    pend_pulse_nxt = pend_pulse_r;
    pend_rev_nxt   = pend_rev_r;
    out_nxt        = '0;

    cnt_inc = {1'b0, cnt_r} + {{PW{1'b0}}, 1'b1};
    pulse   = (s3_q_r >= eff_period) ? (eff_period - {{(PW-1){1'b0}}, 1'b1}) : s3_q_r;
    cmd_dir = s3_neg_r ? hpdc_pkg::DIR_REV : hpdc_pkg::DIR_FWD;

    case (hpdc_pkg::kind_t'(s3_kind_r))
      hpdc_pkg::KIND_TICK: begin
        // counter wraps also when it sits beyond a shrunk period
        if (cnt_inc >= {1'b0, eff_period}) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc[PW-1:0];
        end
        if (cnt_nxt == '0) begin
          fwd_live_nxt = fwd_next_r;
          rev_live_nxt = rev_next_r;
        end
        if (dead_cnt_r != '0) begin
          dead_cnt_nxt = dead_cnt_r - {{(CW-1){1'b0}}, 1'b1};
          if (dead_cnt_nxt == '0) begin
            if (pend_rev_r) begin
              rev_next_nxt = pend_pulse_r;
              dir_nxt      = hpdc_pkg::DIR_REV;
            end else begin
              fwd_next_nxt = pend_pulse_r;
              dir_nxt      = hpdc_pkg::DIR_FWD;
            end
            mode_nxt = hpdc_pkg::MODE_DRIVE;
          end
        end
      end
      hpdc_pkg::KIND_SPEED: begin
        if (dead_cnt_r != '0) begin
          out_nxt.busy_reject = 1'b1;
        end else if (s3_zero_r) begin
          mode_nxt = hpdc_pkg::MODE_COAST;
          dir_nxt  = hpdc_pkg::DIR_NONE;
        end else if (mode_r == hpdc_pkg::MODE_DRIVE && cmd_dir != dir_r &&
                     dead_us_r != '0) begin
          // reversal: coast and hold the new command for the dead time
          mode_nxt       = hpdc_pkg::MODE_COAST;
          dir_nxt        = hpdc_pkg::DIR_NONE;
          dead_cnt_nxt   = dead_ticks_r;
          pend_pulse_nxt = pulse;
          pend_rev_nxt   = s3_neg_r;
        end else begin
          if (s3_neg_r) begin
            rev_next_nxt = pulse;
          end else begin
            fwd_next_nxt = pulse;
          end
          mode_nxt = hpdc_pkg::MODE_DRIVE;
          dir_nxt  = cmd_dir;
        end
      end
      hpdc_pkg::KIND_BRAKE: begin
        if (dead_cnt_r != '0) begin
          out_nxt.busy_reject = 1'b1;
        end else begin
          mode_nxt = hpdc_pkg::MODE_BRAKE;
          dir_nxt  = hpdc_pkg::DIR_NONE;
        end
      end
      default: begin
        // unused kind: no change
      end
    endcase

    if (mode_nxt == hpdc_pkg::MODE_DRIVE) begin
      if (dir_nxt == hpdc_pkg::DIR_FWD) begin
        out_nxt.fwd_drive = (cnt_nxt < fwd_live_nxt);
      end else if (dir_nxt == hpdc_pkg::DIR_REV) begin
        out_nxt.rev_drive = (cnt_nxt < rev_live_nxt);
      end
    end
    out_nxt.bridge_enable = (mode_nxt != hpdc_pkg::MODE_COAST);
    out_nxt.mode_now      = mode_nxt;
    out_nxt.direction_now = dir_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      fwd_live_r   <= '0;
      fwd_next_r   <= '0;
      rev_live_r   <= '0;
      rev_next_r   <= '0;
      mode_r       <= hpdc_pkg::MODE_COAST;
      dir_r        <= hpdc_pkg::DIR_NONE;
      dead_cnt_r   <= '0;
      pend_pulse_r <= '0;
      pend_rev_r   <= 1'b0;
    end else if (step) begin
      cnt_r        <= cnt_nxt;
      fwd_live_r   <= fwd_live_nxt;
      fwd_next_r   <= fwd_next_nxt;
      rev_live_r   <= rev_live_nxt;
      rev_next_r   <= rev_next_nxt;
      mode_r       <= mode_nxt;
      dir_r        <= dir_nxt;
      dead_cnt_r   <= dead_cnt_nxt;
      pend_pulse_r <= pend_pulse_nxt;
      pend_rev_r   <= pend_rev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = vo_r;
  assign out_tdata  = out_r;

  // ---------------- checks ----------------
  // dead-time countdown only runs while coasting
  a_dead_coast: assert property (@(posedge clk) disable iff (!rst_n)
    (dead_cnt_r != '0) |-> (mode_r == hpdc_pkg::MODE_COAST))
    else $error("dead-time countdown running outside coast");

  // a direction is held only in drive
  a_dir_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != hpdc_pkg::MODE_DRIVE) |-> (dir_r == hpdc_pkg::DIR_NONE))
    else $error("direction set outside drive mode");

  // never both bridge inputs driven
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    vo_r |-> !(out_r.fwd_drive && out_r.rev_drive))
    else $error("forward and reverse driven together");

  // a refused command leaves the bridge coasting
  a_reject_coast: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_r.busy_reject) |-> (out_r.mode_now == hpdc_pkg::MODE_COAST))
    else $error("reject reported outside coast");

  // a committed beat shows up on the output
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> vo_r)
    else $error("committed beat lost");

endmodule

[tb/hpdc_checker.sv]
`timescale 1ns / 1ps

module hpdc_checker
  import hpdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          beats_owed
);

  logic [PERIOD_W-1:0] period_q;
  logic [DEAD_W-1:0]   dead_us_q;

  logic [15:0] pwm_count;
  logic [15:0] fwd_cmp_live, fwd_cmp_next;
  logic [15:0] rev_cmp_live, rev_cmp_next;
  mode_t       mode_q;
  logic [1:0]  dir_q;
  logic [22:0] dead_left;
  logic [15:0] held_pulse;
  logic        held_rev;

  // bridge levels still owed by the block, oldest first
  out_beat_t   levels_due[$];

  initial begin
    fail_count = 0;
    beats_owed = 0;
  end

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    fail_count++;
  endtask

  task automatic clear_state();
    period_q     = PERIOD_RESET;
    dead_us_q    = '0;
    pwm_count    = '0;
    fwd_cmp_live = '0;
    fwd_cmp_next = '0;
    rev_cmp_live = '0;
    rev_cmp_next = '0;
    mode_q       = MODE_COAST;
    dir_q        = DIR_NONE;
    dead_left    = '0;
    held_pulse   = '0;
    held_rev     = 1'b0;
    levels_due.delete();
  endtask

  task automatic start_drive(input logic to_rev, input logic [15:0] pulse);
    if (to_rev) rev_cmp_next = pulse;
    else fwd_cmp_next = pulse;
    mode_q = MODE_DRIVE;
    dir_q  = to_rev ? DIR_REV : DIR_FWD;
  endtask

  // one input beat in, the bridge levels after it out
  task automatic step_bridge(input logic [1:0] kind, input logic [15:0] raw,
                             output out_beat_t res);
    int unsigned per;
    int unsigned mag;
    int unsigned pulse;
    int          cmd;
    logic        to_rev;
    logic        parked;
    res    = '0;
    parked = 1'b0;
    per    = (period_q < PERIOD_MIN) ? PERIOD_MIN : period_q;
    if (kind == KIND_TICK) begin
      pwm_count = (pwm_count + 32'd1 >= per) ? 16'd0 : pwm_count + 16'd1;
      if (pwm_count == 16'd0) begin
        fwd_cmp_live = fwd_cmp_next;
        rev_cmp_live = rev_cmp_next;
      end
      if (dead_left != '0) begin
        dead_left = dead_left - 1'b1;
        if (dead_left == '0) start_drive(held_rev, held_pulse);
      end
    end else if (kind == KIND_SPEED || kind == KIND_BRAKE) begin
      if (dead_left != '0) begin
        res.busy_reject = 1'b1;
      end else if (kind == KIND_BRAKE) begin
        mode_q = MODE_BRAKE;
        dir_q  = DIR_NONE;
      end else begin
        cmd = $signed(raw);
        if (cmd > FULL_SCALE) cmd = FULL_SCALE;
        else if (cmd < -FULL_SCALE) cmd = -FULL_SCALE;
        if (cmd == 0) begin
          mode_q = MODE_COAST;
          dir_q  = DIR_NONE;
        end else begin
          to_rev = (cmd < 0);
          mag    = to_rev ? -cmd : cmd;
          pulse  = mag * per / FULL_SCALE;
          if (pulse >= per) pulse = per - 1;
          // reversal out of drive: coast first, maybe wait out the dead time
          if (mode_q == MODE_DRIVE && dir_q != (to_rev ? DIR_REV : DIR_FWD)) begin
            mode_q = MODE_COAST;
            dir_q  = DIR_NONE;
            if (dead_us_q != '0) begin
              dead_left  = 23'(dead_us_q * TICKS_PER_US);
              held_pulse = pulse[15:0];
              held_rev   = to_rev;
              parked     = 1'b1;
            end
          end
          if (!parked) start_drive(to_rev, pulse[15:0]);
        end
      end
    end
    if (mode_q == MODE_DRIVE) begin
      res.fwd_drive = (dir_q == DIR_FWD) && (pwm_count < fwd_cmp_live);
      res.rev_drive = (dir_q == DIR_REV) && (pwm_count < rev_cmp_live);
    end
    res.bridge_enable = (mode_q != MODE_COAST);
    res.mode_now      = mode_q;
    res.direction_now = dir_q;
  endtask

  always @(posedge clk) begin : watch
    out_beat_t got;
    out_beat_t want;
    out_beat_t fresh;
    if (!rst_n) begin
      clear_state();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_beat_t'(out_tdata);
        if (levels_due.size() == 0) begin
          report_mismatch("result beat with nothing pending, tdata", 0, out_tdata);
        end else begin
          want = levels_due.pop_front();
          if (got.fwd_drive !== want.fwd_drive)
            report_mismatch("fwd_drive", want.fwd_drive, got.fwd_drive);
          if (got.rev_drive !== want.rev_drive)
            report_mismatch("rev_drive", want.rev_drive, got.rev_drive);
          if (got.bridge_enable !== want.bridge_enable)
            report_mismatch("bridge_enable", want.bridge_enable, got.bridge_enable);
          if (got.mode_now !== want.mode_now)
            report_mismatch("mode_now", want.mode_now, got.mode_now);
          if (got.direction_now !== want.direction_now)
            report_mismatch("direction_now", $signed(want.direction_now),
                            $signed(got.direction_now));
          if (got.busy_reject !== want.busy_reject)
            report_mismatch("busy_reject", want.busy_reject, got.busy_reject);
        end
      end
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          if (cfg_paddr[2] == REG_DEAD) dead_us_q = cfg_pwdata[DEAD_W-1:0];
          else period_q = cfg_pwdata[PERIOD_W-1:0];
        end else if (cfg_prdata !== {16'd0, (cfg_paddr[2] == REG_DEAD) ? dead_us_q
                                                                          : period_q}) begin
          report_mismatch("register readback",
                          (cfg_paddr[2] == REG_DEAD) ? dead_us_q : period_q, cfg_prdata);
        end
      end
      if (in_tvalid && in_tready) begin
        step_bridge(in_tuser, in_tdata, fresh);
        levels_due.push_back(fresh);
      end
    end
    beats_owed = levels_due.size();
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

// Top of the H-bridge drive controller bench.
// Drives the input stream and the APB-style register port, throttles the
// result stream, and gives the verdict. All prediction and comparison lives in
// hpdc_checker, which watches the same wires and reports its failure count.
module tb;
  import hpdc_pkg::*;

  // kind code the block has to ignore
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] speed
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [0] fwd [1] rev [2] enable [4:3] mode [6:5] dir [7] reject
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int beats_owed;

  // steady: no idling on either side; stall_out_req: one long result hold-off
  bit steady;
  bit stall_out_req;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  hbridge_pwm_drive_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  hpdc_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .fail_count (fail_count),
    .beats_owed (beats_owed)
  );

  // Offer one beat. Gaps (valid low, junk data) come at the falling edge,
  // ~35% per cycle unless steady. Returns right after the accepting edge.
  task automatic offer_beat(input logic [1:0] kind, input logic [15:0] speed);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tuser  <= 2'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= speed;
    do @(posedge clk); while (!in_tready);
  endtask

  // Mostly ticks so the PWM counter and the dead time move; commands carry
  // random signs so reversals come up often.
  task automatic offer_random();
    logic [1:0]  kind;
    logic [15:0] speed;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 78) kind = KIND_TICK;
    else if (pick < 92) kind = KIND_SPEED;
    else if (pick < 97) kind = KIND_BRAKE;
    else kind = KIND_UNUSED;
    pick = $urandom_range(99);
    if (pick < 65) begin
      speed = 16'(int'($urandom_range(20000)) - FULL_SCALE);
    end else if (pick < 80) begin
      case ($urandom_range(6))
        0:       speed = 16'd0;
        1:       speed = 16'(FULL_SCALE);
        2:       speed = 16'(-FULL_SCALE);
        3:       speed = 16'h7fff;
        4:       speed = 16'h8000;
        5:       speed = 16'd1;
        default: speed = 16'hffff;
      endcase
    end else begin
      speed = 16'($urandom);
    end
    offer_beat(kind, speed);
  endtask

  // Stop offering and wait until every owed result beat has come back.
  task automatic settle_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (beats_owed == 0);
    repeat (6) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then release. pready is always high.
  task automatic apb_access(input logic wr, input logic idx, input logic [15:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, val};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write both registers and read them back; block must be idle here.
  task automatic load_regs(input int per, input int dead_us);
    apb_access(1'b1, REG_PERIOD, 16'(per));
    apb_access(1'b1, REG_DEAD, 16'(dead_us));
    apb_access(1'b0, REG_PERIOD, 16'd0);
    apb_access(1'b0, REG_DEAD, 16'd0);
  endtask

  // Result side: random backpressure, plus one long hold-off on request,
  // counted here so the input side keeps offering and the pipe fills up.
  initial begin : sink
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_out_req) begin
        out_tready <= 1'b0;
        repeat (120) @(negedge clk);
        stall_out_req = 1'b0;
      end
      out_tready <= steady || ($urandom_range(99) >= 35);
    end
  end

  // Hard stop in case the block hangs or result beats go missing.
  initial begin : watchdog
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int per_list[8];
    int dead_list[8];
    int len_list[8];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    steady        = 1'b0;
    stall_out_req = 1'b0;
    // random phases: period, dead time, beats. Large period right before a
    // tiny one so the counter sits past the new period and has to wrap.
    per_list  = '{4000, 3, 20, 65535, 2, 97, 1, 500};
    dead_list = '{0, 0, 1, 0, 2, 0, 0, 3};
    len_list  = '{300, 200, 250, 150, 250, 400, 100, 300};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed: short period, no dead time ---
    load_regs(10, 0);
    repeat (3) offer_beat(KIND_TICK, 16'h0000);
    offer_beat(KIND_SPEED, 16'(FULL_SCALE));     // full forward, duty clamps to period-1
    repeat (4) offer_beat(KIND_TICK, 16'hffff);
    offer_beat(KIND_SPEED, 16'(-FULL_SCALE));    // reversal with zero dead time
    repeat (2) offer_beat(KIND_TICK, 16'h5a5a);
    offer_beat(KIND_SPEED, 16'h7fff);             // saturates, reverses again
    offer_beat(KIND_SPEED, 16'h8000);             // most negative, saturates
    offer_beat(KIND_SPEED, 16'd0);                // coast
    offer_beat(KIND_SPEED, 16'd1);                // tiny duty rounds to zero
    offer_beat(KIND_SPEED, 16'hffff);
    offer_beat(KIND_BRAKE, 16'h1234);
    offer_beat(KIND_TICK, 16'h0000);
    offer_beat(KIND_UNUSED, 16'hffff);            // ignored kind
    offer_beat(KIND_SPEED, 16'd5000);
    offer_beat(KIND_TICK, 16'h0000);
    settle_results();

    // --- directed: period below minimum, one microsecond of dead time ---
    load_regs(0, 1);
    offer_beat(KIND_SPEED, 16'd3000);
    offer_beat(KIND_TICK, 16'h0000);
    offer_beat(KIND_SPEED, 16'(-3000));           // reversal parks in coast
    offer_beat(KIND_SPEED, 16'd100);              // refused during countdown
    offer_beat(KIND_BRAKE, 16'h0000);             // refused too
    offer_beat(KIND_UNUSED, 16'h0000);
    repeat (TICKS_PER_US) offer_beat(KIND_TICK, 16'h0000);  // countdown expires
    offer_beat(KIND_TICK, 16'h0000);
    settle_results();

    // --- random phases ---
    for (int ph = 0; ph < 8; ph++) begin
      load_regs(per_list[ph], dead_list[ph]);
      for (int n = 0; n < len_list[ph]; n++) begin
        steady = (ph == 5 && n >= 100 && n < 350);
        if (ph == 5 && n == 50) stall_out_req = 1'b1;
        if (ph == 0 && n == 150) settle_results();
        offer_random();
      end
      steady = 1'b0;
      settle_results();
    end

    // --- longest dead time: one reversal and it never ends in this run ---
    load_regs(4000, 65535);
    offer_beat(KIND_SPEED, 16'd0);
    offer_beat(KIND_SPEED, 16'd8000);
    repeat (5) offer_beat(KIND_TICK, 16'h0000);
    offer_beat(KIND_SPEED, 16'(-8000));
    offer_beat(KIND_SPEED, 16'd0);
    offer_beat(KIND_BRAKE, 16'h0000);
    repeat (15) offer_random();
    settle_results();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
